@@ design/nearest_point_search_assert.svh @@
// Assertion macros used by the nearest point search port checks.
`ifndef NEAREST_POINT_SEARCH_ASSERT_SVH
`define NEAREST_POINT_SEARCH_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define NPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define NPS_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nps_pkg.sv @@
// Types, widths and helpers shared by the nearest point search modules.
package nps_pkg;

  // Field widths of the stream items.
  localparam int COORD_BITS  = 16;
  localparam int SLOT_W      = 10;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int SQ_W        = 2 * COORD_BITS + 1;
  localparam int DIST_W      = 2 * COORD_BITS + 2;

  // Default store depth.
  localparam int MAX_POINTS_DEF = 1024;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Input tdata layout: slot, x, y, z from bit 0 up, padded to bytes.
  localparam int IN_SLOT_LO  = 0;
  localparam int IN_X_LO     = IN_SLOT_LO + SLOT_W;
  localparam int IN_Y_LO     = IN_X_LO + COORD_BITS;
  localparam int IN_Z_LO     = IN_Y_LO + COORD_BITS;
  localparam int IN_USED_W   = IN_Z_LO + COORD_BITS;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout: index then distance, padded to bytes.
  localparam int OUT_USED_W  = IDX_W + DIST_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    point_t            pt;
  } cmd_t;

  // Square of the difference of two coordinates; always non-negative.
  function automatic logic [SQ_W-1:0] sq_diff(logic signed [COORD_BITS-1:0] a,
                                               logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0]   d;
    logic signed [2*DIFF_W-1:0] p;
    d = DIFF_W'(a) - DIFF_W'(b);
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

endpackage

@@ design/nps_front.sv @@
// Input stage: takes stream transfers, decodes them and drops loads beyond the store.
module nps_front
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]            in_tuser,
  output logic                  push_valid,
  input  logic                  push_ready,
  output cmd_t                  push_cmd
);

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_r;
  cmd_t dec;
  logic accept;
  logic keep;

  // Unpack the transfer into a command.
  always_comb begin
    dec.op   = op_t'(in_tuser[0]);
    dec.slot = in_tdata[IN_SLOT_LO +: SLOT_W];
    dec.pt.x = in_tdata[IN_X_LO +: COORD_BITS];
    dec.pt.y = in_tdata[IN_Y_LO +: COORD_BITS];
    dec.pt.z = in_tdata[IN_Z_LO +: COORD_BITS];
  end

  // A load aimed past the end of the store is consumed and forgotten.
  assign keep      = (dec.op == OP_QUERY) || (32'(dec.slot) < 32'(MAX_POINTS));
  assign in_tready = !hold_valid_r || push_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    hold_valid_nxt = hold_valid_r && !push_ready;
    if (accept) begin
      hold_valid_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= dec;
    end
  end

  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_r;

endmodule

@@ design/nps_queue.sv @@
// Short command queue that decouples the front stage from the search engine.
module nps_queue
  import nps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            ent_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != NW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = ent_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/nps_back.sv @@
// Search engine: point memory, scan sequencer, distance pipeline and result register.
module nps_back
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [IDX_W-1:0]  res_index,
  output logic [DIST_W-1:0] res_dist
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // Configuration and sequencing state.
  logic [CNT_W-1:0]  point_count_r;
  state_t            state_r, state_nxt;
  point_t            tgt_r;
  logic [AW-1:0]     scan_addr_r, last_addr_r;
  logic [CW-1:0]     n_sat;

  // Point memory.
  point_t            mem_r [MAX_POINTS];
  logic [AW-1:0]     wr_addr;

  // Pipeline stages.
  logic              p1_valid_r, p1_last_r;
  logic [AW-1:0]     p1_idx_r;
  point_t            rd_data_r;
  logic              p2_valid_r, p2_last_r;
  logic [AW-1:0]     p2_idx_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r, sq_z_r;
  logic              p3_valid_r, p3_last_r;
  logic [AW-1:0]     p3_idx_r;
  logic [DIST_W-1:0] sum_r;

  // Best so far and result register.
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic              take;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;

  // Sequencer controls.
  logic wr_en, start, issue, empty_res;

  // Scan length, clipped to the store depth.
  always_comb begin
    if (32'(point_count_r) > 32'(MAX_POINTS)) begin
      n_sat = CW'(MAX_POINTS);
    end else begin
      n_sat = CW'(point_count_r);
    end
  end

  assign wr_addr = AW'(cmd.slot);

  // Next state and sequencer outputs.
  always_comb begin
    state_nxt = state_r;
    cmd_ready = 1'b0;
    wr_en     = 1'b0;
    start     = 1'b0;
    issue     = 1'b0;
    empty_res = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_LOAD) begin
            cmd_ready = 1'b1;
            wr_en     = 1'b1;
          end else if (!out_valid_r || res_ready) begin
            cmd_ready = 1'b1;
            if (n_sat == '0) begin
              empty_res = 1'b1;
            end else begin
              start     = 1'b1;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (scan_addr_r == last_addr_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (p3_valid_r && p3_last_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      point_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        point_count_r <= cfg_wr_data;
      end
    end
  end

  // Query set-up and scan address.
  always_ff @(posedge clk) begin
    if (start) begin
      tgt_r       <= cmd.pt;
      scan_addr_r <= '0;
      last_addr_r <= AW'(n_sat - CW'(1));
    end else if (issue) begin
      scan_addr_r <= scan_addr_r + AW'(1);
    end
  end

  // Memory: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= cmd.pt;
    end
    if (issue) begin
      rd_data_r <= mem_r[scan_addr_r];
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= issue;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
    end
  end

  // Pipeline payload: tags, squared differences, then their sum.
  always_ff @(posedge clk) begin
    p1_last_r <= (scan_addr_r == last_addr_r);
    p1_idx_r  <= scan_addr_r;
    p2_last_r <= p1_last_r;
    p2_idx_r  <= p1_idx_r;
    sq_x_r    <= sq_diff(rd_data_r.x, tgt_r.x);
    sq_y_r    <= sq_diff(rd_data_r.y, tgt_r.y);
    sq_z_r    <= sq_diff(rd_data_r.z, tgt_r.z);
    p3_last_r <= p2_last_r;
    p3_idx_r  <= p2_idx_r;
    sum_r     <= DIST_W'(sq_x_r) + DIST_W'(sq_y_r) + DIST_W'(sq_z_r);
  end

  // Running minimum; the first point is always taken, then only a strictly smaller distance replaces the best.
  always_comb begin
    take          = (p3_idx_r == '0) || (sum_r < best_dist_r);
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    if (p3_valid_r && take) begin
      best_idx_nxt  = p3_idx_r;
      best_dist_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
  end

  // Result register, held until the downstream side takes it.
  always_comb begin
    out_valid_nxt = out_valid_r && !res_ready;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;
    if (empty_res) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = '0;
      out_dist_nxt  = '1;
    end else if (p3_valid_r && p3_last_r) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = IDX_W'(best_idx_nxt);
      out_dist_nxt  = best_dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r  <= out_idx_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign res_valid = out_valid_r;
  assign res_index = out_idx_r;
  assign res_dist  = out_dist_r;

endmodule

@@ design/nearest_point_search.sv @@
// Top level of the nearest point search: front stage, command queue and search engine.
//
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_tvalid/tready    | tuser: cmd; tdata: slot, x, y, z
//  out_    | output    | out_tvalid/tready   | tdata: nearest_index, min_distance_sq
//  cfg_    | input     | cfg_wr_en           | cfg_wr_data: point_count
//
// A load is written while the search engine is idle. A query holds the engine
// through a scan of N = min(point_count, MAX_POINTS) points, one point read per
// cycle from the single read port of the point memory; an empty set is answered
// without a scan. Front stage and queue register each command and keep taking
// transfers while the engine is busy or a result waits, until full. Reset clears
// control state only; the point memory holds nothing defined until loaded.
module nearest_point_search
  import nps_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot, coord_x, coord_y, coord_z, zero pad
  input  logic [0:0]             in_tuser,   // cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // nearest_index, min_distance_sq, zero pad
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data
);

  logic              fq_valid, fq_ready;
  cmd_t              fq_cmd;
  logic              qb_valid, qb_ready;
  cmd_t              qb_cmd;
  logic [IDX_W-1:0]  res_index;
  logic [DIST_W-1:0] res_dist;

  nps_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd)
  );

  nps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  nps_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (qb_valid),
    .cmd_ready   (qb_ready),
    .cmd         (qb_cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_index   (res_index),
    .res_dist    (res_dist)
  );

  // Pack the result fields, index in the lowest bits.
  assign out_tdata = OUT_TDATA_W'({res_dist, res_index});

endmodule

@@ design/nps_checker.sv @@
// Port-level checks on the nearest point search, bound to the top level.
`include "nearest_point_search_assert.svh"

module nps_props
  import nps_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A result waiting on the downstream side keeps its value.
  `NPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // No result is offered in the cycle after reset.
  `NPS_ASSERT_RESET(a_out_reset, !rst_n, !out_tvalid, "result valid after reset")

  // The all-ones distance only comes from an empty set, which reports slot zero.
  `NPS_ASSERT_SAME(a_empty_idx, out_tvalid && (out_tdata[OUT_USED_W-1:IDX_W] == '1), out_tdata[IDX_W-1:0] == '0, "empty set result with non-zero index")

  // A real distance never exceeds three full-range squared differences.
  `NPS_ASSERT_SAME(a_dist_range, out_tvalid, (out_tdata[OUT_USED_W-1:IDX_W] < 34'd12884508676) || (out_tdata[OUT_USED_W-1:IDX_W] == '1), "distance out of range")

endmodule

bind nearest_point_search nps_props u_nps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/nps_checker.sv @@
// Checker for the nearest point search: mirrors the point store, predicts each answer and compares.
module nps_checker
  import nps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot, coord_x, coord_y, coord_z, zero pad
  input  logic [0:0]             in_tuser,   // cmd
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // nearest_index, min_distance_sq, zero pad
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data,
  output int                     fail_count,
  output int                     awaiting,
  output int                     checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted answer to a query, tagged with the query's sequence number.
  typedef struct {
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] dist_sq;
    int                query_no;
  } search_result_t;

  // Mirror of the block's store and its point count register.
  point_t         pts [MAX_POINTS_DEF];
  logic [CNT_W-1:0] scan_count;
  search_result_t nearest_q [$];
  int             queries_seen;

  // Scratch for the monitor process.
  point_t            q_pt;
  search_result_t    want;
  logic [IDX_W-1:0]  got_index;
  logic [DIST_W-1:0] got_dist;

  // Exact squared Euclidean distance between two Q8.8 points.
  function automatic logic [DIST_W-1:0] dist_sq(point_t a, point_t b);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'($signed(a.x)) - longint'($signed(b.x));
    dy = longint'($signed(a.y)) - longint'($signed(b.y));
    dz = longint'($signed(a.z)) - longint'($signed(b.z));
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Linear scan over the active slots; only a strictly smaller distance wins, so ties keep
  // the lower slot. An empty set answers slot 0 at the largest distance.
  function automatic search_result_t find_nearest(point_t target);
    search_result_t    best;
    logic [DIST_W-1:0] d;
    int                n;
    int                j;
    n = (scan_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(scan_count);
    best.index    = '0;
    best.dist_sq  = '1;
    best.query_no = 0;
    for (j = 0; j < n; j++) begin
      d = dist_sq(pts[j], target);
      if (j == 0 || d < best.dist_sq) begin
        best.dist_sq = d;
        best.index   = IDX_W'(j);
      end
    end
    return best;
  endfunction

  // Prints one line per mismatch (only the first 40) and counts every one.
  task automatic report_mismatch(string msg);
    if (fail_count < 40) $display("%0t ns mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Monitor all three ports at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      scan_count   = '0;
      queries_seen = 0;
      nearest_q.delete();
    end else begin
      if (cfg_wr_en) scan_count = cfg_wr_data;

      // An input transfer either updates the store or queues the predicted answer.
      if (in_tvalid && in_tready) begin
        q_pt.x = in_tdata[IN_X_LO +: COORD_BITS];
        q_pt.y = in_tdata[IN_Y_LO +: COORD_BITS];
        q_pt.z = in_tdata[IN_Z_LO +: COORD_BITS];
        if (op_t'(in_tuser[0]) == OP_QUERY) begin
          want          = find_nearest(q_pt);
          want.query_no = queries_seen;
          queries_seen++;
          nearest_q.push_back(want);
        end else begin
          pts[in_tdata[IN_SLOT_LO +: SLOT_W]] = q_pt;
        end
      end

      // A result transfer is compared with the oldest outstanding answer.
      if (out_tvalid && out_tready) begin
        if (nearest_q.size() == 0) begin
          report_mismatch("result transfer with no query outstanding");
        end else begin
          want      = nearest_q.pop_front();
          got_index = out_tdata[0 +: IDX_W];
          got_dist  = out_tdata[IDX_W +: DIST_W];
          if (got_index !== want.index)
            report_mismatch($sformatf("query %0d: nearest_index %0d, predicted %0d",
                                      want.query_no, got_index, want.index));
          if (got_dist !== want.dist_sq)
            report_mismatch($sformatf("query %0d: min_distance_sq %0d, predicted %0d",
                                      want.query_no, got_dist, want.dist_sq));
          checked++;
        end
      end
    end
    awaiting = nearest_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the nearest point search testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nps_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int GAP_CAP     = 30;
  localparam int STALL_CAP   = 40;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [0:0]             in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;

  int fail_count;
  int awaiting;
  int checked;

  // Stimulus bookkeeping: what has been loaded where, and the current point count.
  point_t shadow [MAX_POINTS_DEF];
  bit     loaded [MAX_POINTS_DEF];
  int     loaded_prefix = 0;
  int     cur_count     = 0;
  int     tx_idle_pct   = 38;
  int     rx_idle_pct   = 82;
  int     stall_run     = 0;
  logic   in_taken      = 1'b0;
  int     quiet         = 0;
  int     loads_sent    = 0;
  int     queries_sent  = 0;
  int     count_writes  = 0;
  int     widest_count  = 0;
  int     random_items  = 0;

  nearest_point_search u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  nps_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .awaiting    (awaiting),
    .checked     (checked)
  );

  // 2 ns clock.
  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  // Note whether the input transfer completed at this edge; the sender looks at it later.
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
  end

  // Receiver: random back-pressure with a bounded stall length.
  always @(negedge clk) begin
    if (stall_run < STALL_CAP && $urandom_range(99) < rx_idle_pct) begin
      out_tready = 1'b0;
      stall_run++;
    end else begin
      out_tready = 1'b1;
      stall_run  = 0;
    end
  end

  // Watchdog: too long without any transfer or register write ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d answers outstanding",
               QUIET_LIMIT, awaiting);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Coordinates biased towards the extremes and towards a small cluster round the origin.
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      case ($urandom_range(3))
        0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
        1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pick <= 2) return COORD_BITS'(int'($urandom_range(8)) - 4);
    return COORD_BITS'($urandom);
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    return p;
  endfunction

  // Drive one input transfer after a random gap and hold it until it is taken.
  task automatic send(op_t op, logic [SLOT_W-1:0] slot, point_t p);
    int gap;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata                         = '0;
    in_tdata[IN_SLOT_LO +: SLOT_W]   = slot;
    in_tdata[IN_X_LO +: COORD_BITS]  = p.x;
    in_tdata[IN_Y_LO +: COORD_BITS]  = p.y;
    in_tdata[IN_Z_LO +: COORD_BITS]  = p.z;
    in_tuser                         = op;
    in_tvalid                        = 1'b1;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  task automatic load_point(logic [SLOT_W-1:0] slot, point_t p);
    shadow[slot] = p;
    loaded[slot] = 1'b1;
    while (loaded_prefix < MAX_POINTS_DEF && loaded[loaded_prefix]) loaded_prefix++;
    loads_sent++;
    send(OP_LOAD, slot, p);
  endtask

  // The slot field of a query is don't-care, so it carries noise.
  task automatic query_point(point_t p);
    queries_sent++;
    send(OP_QUERY, SLOT_W'($urandom), p);
  endtask

  // Wait until every answer is in and the pipeline has had time to empty.
  task automatic settle();
    in_tvalid = 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Load any slot the new count would scan that was never written, then write the register.
  task automatic set_count(int value);
    int need;
    int s;
    need = (value > MAX_POINTS_DEF) ? MAX_POINTS_DEF : value;
    for (s = 0; s < need; s++)
      if (!loaded[s]) load_point(SLOT_W'(s), rand_point());
    settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = CNT_W'(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_count = value;
    count_writes++;
    if (value > widest_count) widest_count = value;
  endtask

  // Empty set, the farthest possible pair, exact hits and a tie between equal points.
  task automatic directed_items();
    point_t lo;
    point_t hi;
    point_t org;
    point_t p;
    lo  = {3{1'b1, {(COORD_BITS-1){1'b0}}}};
    hi  = {3{1'b0, {(COORD_BITS-1){1'b1}}}};
    org = '0;
    query_point(org);
    set_count(0);
    query_point(hi);
    load_point(SLOT_W'(0), lo);
    load_point(SLOT_W'(1), hi);
    load_point(SLOT_W'(2), org);
    load_point(SLOT_W'(3), org);
    load_point('1, {16'h5555, 16'haaaa, 16'h00ff});
    load_point(SLOT_W'(10'h2aa), {16'haaaa, 16'h5555, 16'hff00});
    set_count(1);
    query_point(hi);
    set_count(4);
    query_point(lo);
    query_point(hi);
    query_point(org);
    p = {16'h0001, 16'hffff, 16'h0001};
    query_point(p);
    p = {16'h7fff, 16'h8000, 16'h0000};
    query_point(p);
  endtask

  // One round: pick a point count, then a burst of loads and queries against it.
  task automatic random_round(int forced);
    int          n_items;
    int          k;
    int          eff;
    int unsigned r;
    point_t      p;
    logic [SLOT_W-1:0] slot;
    if (forced >= 0) begin
      set_count(forced);
    end else begin
      r = $urandom_range(99);
      if (r < 8)       set_count(0);
      else if (r < 80) set_count($urandom_range(1, 12));
      else             set_count($urandom_range(13, 64));
    end
    eff     = (cur_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cur_count;
    n_items = $urandom_range(8, 24);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 55) begin
        // Queries: random, or a stored point possibly nudged by one step.
        p = rand_point();
        if (eff > 0 && $urandom_range(3) == 0) begin
          p = shadow[$urandom_range(eff - 1)];
          if ($urandom_range(1) == 1) p.x = p.x + COORD_BITS'(int'($urandom_range(2)) - 1);
        end
        query_point(p);
      end else begin
        // Loads: mostly into the scanned range, sometimes a copy of a stored point.
        if ($urandom_range(99) < 60) slot = SLOT_W'($urandom_range(((eff > 0) ? eff : 1) - 1));
        else                         slot = SLOT_W'($urandom);
        p = rand_point();
        if (loaded_prefix > 0 && $urandom_range(4) == 0)
          p = shadow[$urandom_range(loaded_prefix - 1)];
        load_point(slot, p);
      end
    end
    random_items += n_items;
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, int target, int opening);
    int start;
    int first;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start       = random_items;
    first       = opening;
    while (random_items - start < target) begin
      random_round(first);
      first = -1;
    end
  endtask

  // Main sequence: reset, directed items, then three phases of random traffic.
  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    directed_items();
    run_phase(38, 82, 165, -1);
    run_phase(82, 38, 165, 64);
    run_phase(0, 0, 165, -1);
    settle();
    repeat (12) @(negedge clk);
    $display("Sent %0d loads and %0d queries over %0d point count settings (up to %0d).",
             loads_sent, queries_sent, count_writes, widest_count);
    $display("%0d answers compared, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/nps_pkg.sv
design/nps_front.sv
design/nps_queue.sv
design/nps_back.sv
design/nearest_point_search.sv
design/nps_checker.sv
tb/nps_checker.sv
tb/testbench.sv
